// ===== sv/qrpm_pkg.sv =====
// shared constants, types and register codes for the quad rate pid mixer
`default_nettype none

package qrpm_pkg;

  localparam int RATE_FRAC_BITS = 4;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int RATE_W     = 16;
  localparam int TARGET_W   = 14;
  localparam int ERR_W      = 17;
  localparam int GAIN_W     = 18;
  localparam int LIMIT_W    = 10;
  localparam int THR_W      = 11;
  localparam int PID_W      = 11;
  localparam int MOTOR_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 48;

  localparam logic [MOTOR_W-1:0] MOTOR_IDLE = 11'd1000;
  localparam logic [MOTOR_W-1:0] MOTOR_LOW  = 11'd1050;
  localparam logic [MOTOR_W-1:0] MOTOR_HIGH = 11'd1950;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_RP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_RP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_RP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_YW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_YW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_YW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P_RP = 18'd5734;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I_RP = 18'd164;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D_RP = 18'd73728;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P_YW = 18'd16384;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I_YW = 18'd82;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D_YW = 18'd0;
  localparam logic [LIMIT_W-1:0] RST_LIMIT     = 10'd400;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  // pipeline advance strobes shared by the three axis units
  typedef struct packed {
    logic adv_b;
    logic adv_c;
  } axis_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/qrpm_axis.sv =====
// one pid axis: products stage, then integral update and output clamp stage
`default_nettype none

module qrpm_axis #(
  parameter int RATE_FRAC_BITS = qrpm_pkg::RATE_FRAC_BITS,
  parameter int GAIN_FRAC_BITS = qrpm_pkg::GAIN_FRAC_BITS
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  qrpm_pkg::axis_ctrl_t                       ctrl_i,
  input  wire logic signed [qrpm_pkg::ERR_W-1:0]     err_i,
  input  wire                                        clear_i,
  input  qrpm_pkg::gains_t                           gains_i,
  input  wire logic [qrpm_pkg::LIMIT_W-1:0]          limit_i,
  output logic signed [qrpm_pkg::PID_W-1:0]          pid_o
);

  localparam int ERR_W   = qrpm_pkg::ERR_W;
  localparam int GAIN_W  = qrpm_pkg::GAIN_W;
  localparam int LIMIT_W = qrpm_pkg::LIMIT_W;
  localparam int PID_W   = qrpm_pkg::PID_W;
  localparam int INTEG_W = LIMIT_W + RATE_FRAC_BITS + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int PI_W    = GAIN_W + 1 + ERR_W;
  localparam int PD_W    = GAIN_W + 1 + DIFF_W;
  localparam int STEP_W  = PI_W - GAIN_FRAC_BITS;
  localparam int ISUM_W  = ((STEP_W > INTEG_W) ? STEP_W : INTEG_W) + 1;
  localparam int ISH_W   = INTEG_W + GAIN_FRAC_BITS;
  localparam int SUM_W   = ((PD_W > ISH_W) ? PD_W : ISH_W) + 2;
  localparam int SHIFT   = RATE_FRAC_BITS + GAIN_FRAC_BITS;

  // stage b: products
  logic signed [ERR_W-1:0]   prev_q;
  logic signed [PI_W-1:0]    prod_p_q, prod_p_d;
  logic signed [PI_W-1:0]    prod_i_q, prod_i_d;
  logic signed [PD_W-1:0]    prod_d_q, prod_d_d;
  logic                      clear_b_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ERR_W-1:0]   prev_base;
  logic signed [GAIN_W:0]    gp_s, gi_s, gd_s;

  // stage c: integral and pid sum
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [PID_W-1:0]   pid_q, pid_d;
  logic signed [PI_W-1:0]    step_full;
  logic signed [STEP_W-1:0]  step;
  logic signed [INTEG_W-1:0] integ_base;
  logic signed [ISUM_W-1:0]  isum, ilim;
  logic signed [SUM_W-1:0]   sum, sum_sh, lim_s;

  always_comb begin
    gp_s      = $signed({1'b0, gains_i.p});
    gi_s      = $signed({1'b0, gains_i.i});
    gd_s      = $signed({1'b0, gains_i.d});
    prev_base = clear_i ? '0 : prev_q;
    diff      = DIFF_W'(err_i) - DIFF_W'(prev_base);
    prod_p_d  = PI_W'(gp_s) * PI_W'(err_i);
    prod_i_d  = PI_W'(gi_s) * PI_W'(err_i);
    prod_d_d  = PD_W'(gd_s) * PD_W'(diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      clear_b_q <= 1'b0;
    end else if (ctrl_i.adv_b) begin
      prev_q    <= err_i;
      clear_b_q <= clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv_b) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  always_comb begin
    // arithmetic shift floors toward minus infinity
    step_full  = prod_i_q >>> GAIN_FRAC_BITS;
    step       = step_full[STEP_W-1:0];
    integ_base = clear_b_q ? '0 : integ_q;
    isum       = ISUM_W'(integ_base) + ISUM_W'(step);
    ilim       = ISUM_W'($signed({1'b0, limit_i})) <<< RATE_FRAC_BITS;
    if (isum > ilim) begin
      integ_d = ilim[INTEG_W-1:0];
    end else if (isum < -ilim) begin
      integ_d = INTEG_W'(-ilim);
    end else begin
      integ_d = isum[INTEG_W-1:0];
    end

    sum    = SUM_W'(prod_p_q) + (SUM_W'(integ_d) <<< GAIN_FRAC_BITS) + SUM_W'(prod_d_q);
    sum_sh = sum >>> SHIFT;
    lim_s  = SUM_W'($signed({1'b0, limit_i}));
    if (sum_sh > lim_s) begin
      pid_d = lim_s[PID_W-1:0];
    end else if (sum_sh < -lim_s) begin
      pid_d = PID_W'(-lim_s);
    end else begin
      pid_d = sum_sh[PID_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.adv_c) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv_c) begin
      pid_q <= pid_d;
    end
  end

  assign pid_o = pid_q;

endmodule

`default_nettype wire

// ===== sv/qrpm_mixer.sv =====
// x-quad motor mix, pulse clamp and disarm idle, into the result register
`default_nettype none

module qrpm_mixer (
  input  wire                                      clk_i,
  input  wire                                      load_i,
  input  wire logic signed [qrpm_pkg::PID_W-1:0]   roll_i,
  input  wire logic signed [qrpm_pkg::PID_W-1:0]   pitch_i,
  input  wire logic signed [qrpm_pkg::PID_W-1:0]   yaw_i,
  input  wire logic [qrpm_pkg::THR_W-1:0]          throttle_i,
  input  wire                                      armed_i,
  output logic [qrpm_pkg::MOTOR_W-1:0]             front_right_o,
  output logic [qrpm_pkg::MOTOR_W-1:0]             rear_right_o,
  output logic [qrpm_pkg::MOTOR_W-1:0]             rear_left_o,
  output logic [qrpm_pkg::MOTOR_W-1:0]             front_left_o
);

  localparam int MIX_W   = qrpm_pkg::THR_W + 3;
  localparam int MOTOR_W = qrpm_pkg::MOTOR_W;

  logic signed [MIX_W-1:0]  t_s, r_s, p_s, y_s;
  logic signed [MIX_W-1:0]  mix_fr, mix_rr, mix_rl, mix_fl;
  logic [MOTOR_W-1:0]       fr_d, rr_d, rl_d, fl_d;
  logic [MOTOR_W-1:0]       fr_q, rr_q, rl_q, fl_q;

  function automatic logic [MOTOR_W-1:0] motor_clamp(input logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] lo;
    logic signed [MIX_W-1:0] hi;
    lo = MIX_W'($signed({1'b0, qrpm_pkg::MOTOR_LOW}));
    hi = MIX_W'($signed({1'b0, qrpm_pkg::MOTOR_HIGH}));
    if (v < lo) begin
      return qrpm_pkg::MOTOR_LOW;
    end else if (v > hi) begin
      return qrpm_pkg::MOTOR_HIGH;
    end
    return v[MOTOR_W-1:0];
  endfunction

  always_comb begin
    t_s    = MIX_W'($signed({1'b0, throttle_i}));
    r_s    = MIX_W'(roll_i);
    p_s    = MIX_W'(pitch_i);
    y_s    = MIX_W'(yaw_i);
    mix_fr = t_s - p_s + r_s - y_s;
    mix_rr = t_s + p_s + r_s + y_s;
    mix_rl = t_s + p_s - r_s - y_s;
    mix_fl = t_s - p_s - r_s + y_s;
    if (armed_i) begin
      fr_d = motor_clamp(mix_fr);
      rr_d = motor_clamp(mix_rr);
      rl_d = motor_clamp(mix_rl);
      fl_d = motor_clamp(mix_fl);
    end else begin
      fr_d = qrpm_pkg::MOTOR_IDLE;
      rr_d = qrpm_pkg::MOTOR_IDLE;
      rl_d = qrpm_pkg::MOTOR_IDLE;
      fl_d = qrpm_pkg::MOTOR_IDLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fr_q <= fr_d;
      rr_q <= rr_d;
      rl_q <= rl_d;
      fl_q <= fl_d;
    end
  end

  assign front_right_o = fr_q;
  assign rear_right_o  = rr_q;
  assign rear_left_o   = rl_q;
  assign front_left_o  = fl_q;

endmodule

`default_nettype wire

// ===== sv/quad_rate_pid_mixer_core.sv =====
// top level of the quad rate pid mixer: input stage, axis units, mixer, handshakes
//
// Rate pid controller for a quad frame with x-mix motor output.
// Input stream: one beat per control tick carrying three gyro rates, three
// rate setpoints, throttle, the armed flag and the clear flag in s_axis_tdata_i.
// Output stream: one beat per input beat with the four motor pulses.
// Configuration: gains and the output limit are written through cfg_we_i,
// cfg_index_i and cfg_data_i; write only while no beat is in flight.
// An accepted input beat passes four registers (error, gain products, integral
// and clamp, mix) before m_axis_tvalid_o rises.
// Throughput: one beat per cycle while m_axis_tready_i is high; every stage holds
// one beat and advances whenever the stage after it is empty or moving.
// Reset clears the valid bits, the integrals and previous errors, and loads
// the default gains and limit.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling; s_axis_tready_o drops only once all four
// stages hold a beat.
`default_nettype none

module quad_rate_pid_mixer_core #(
  parameter int RATE_FRAC_BITS = qrpm_pkg::RATE_FRAC_BITS,
  parameter int GAIN_FRAC_BITS = qrpm_pkg::GAIN_FRAC_BITS
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // roll_rate, pitch_rate, yaw_rate, roll_target, pitch_target, yaw_target,
  // base_throttle, armed, clear_loop, one zero pad bit
  input  wire logic [qrpm_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire                                     m_axis_tready_i,
  // motor_front_right, motor_rear_right, motor_rear_left, motor_front_left,
  // four zero pad bits
  output logic [qrpm_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  input  wire                                     cfg_we_i,
  input  wire logic [qrpm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [qrpm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int RATE_W   = qrpm_pkg::RATE_W;
  localparam int TARGET_W = qrpm_pkg::TARGET_W;
  localparam int ERR_W    = qrpm_pkg::ERR_W;
  localparam int THR_W    = qrpm_pkg::THR_W;
  localparam int PID_W    = qrpm_pkg::PID_W;
  localparam int MOTOR_W  = qrpm_pkg::MOTOR_W;
  localparam int GAIN_W   = qrpm_pkg::GAIN_W;
  localparam int LIMIT_W  = qrpm_pkg::LIMIT_W;

  // configuration
  logic [GAIN_W-1:0]  gp_rp_q, gi_rp_q, gd_rp_q, gp_yw_q, gi_yw_q, gd_yw_q;
  logic [LIMIT_W-1:0] limit_q;
  qrpm_pkg::gains_t   gains_rp, gains_yw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_rp_q <= qrpm_pkg::RST_GAIN_P_RP;
      gi_rp_q <= qrpm_pkg::RST_GAIN_I_RP;
      gd_rp_q <= qrpm_pkg::RST_GAIN_D_RP;
      gp_yw_q <= qrpm_pkg::RST_GAIN_P_YW;
      gi_yw_q <= qrpm_pkg::RST_GAIN_I_YW;
      gd_yw_q <= qrpm_pkg::RST_GAIN_D_YW;
      limit_q <= qrpm_pkg::RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qrpm_pkg::REG_GAIN_P_RP: gp_rp_q <= cfg_data_i[GAIN_W-1:0];
        qrpm_pkg::REG_GAIN_I_RP: gi_rp_q <= cfg_data_i[GAIN_W-1:0];
        qrpm_pkg::REG_GAIN_D_RP: gd_rp_q <= cfg_data_i[GAIN_W-1:0];
        qrpm_pkg::REG_GAIN_P_YW: gp_yw_q <= cfg_data_i[GAIN_W-1:0];
        qrpm_pkg::REG_GAIN_I_YW: gi_yw_q <= cfg_data_i[GAIN_W-1:0];
        qrpm_pkg::REG_GAIN_D_YW: gd_yw_q <= cfg_data_i[GAIN_W-1:0];
        qrpm_pkg::REG_LIMIT:     limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign gains_rp = '{p: gp_rp_q, i: gi_rp_q, d: gd_rp_q};
  assign gains_yw = '{p: gp_yw_q, i: gi_yw_q, d: gd_yw_q};

  // input field unpacking
  logic signed [RATE_W-1:0]   roll_rate, pitch_rate, yaw_rate;
  logic signed [TARGET_W-1:0] roll_target, pitch_target, yaw_target;
  logic [THR_W-1:0]           base_throttle, thr_capped;
  logic                       armed, clear_loop;

  assign roll_rate     = s_axis_tdata_i[15:0];
  assign pitch_rate    = s_axis_tdata_i[31:16];
  assign yaw_rate      = s_axis_tdata_i[47:32];
  assign roll_target   = s_axis_tdata_i[61:48];
  assign pitch_target  = s_axis_tdata_i[75:62];
  assign yaw_target    = s_axis_tdata_i[89:76];
  assign base_throttle = s_axis_tdata_i[100:90];
  assign armed         = s_axis_tdata_i[101];
  assign clear_loop    = s_axis_tdata_i[102];
  assign thr_capped    = (base_throttle > qrpm_pkg::MOTOR_HIGH) ? qrpm_pkg::MOTOR_HIGH
                                                              : base_throttle;

  // stage handshake: a stage moves when the next one is empty or moving
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: errors and side fields
  logic signed [ERR_W-1:0] err_r_q, err_p_q, err_y_q;
  logic                    clear1_q, armed1_q, armed2_q, armed3_q;
  logic [THR_W-1:0]        thr1_q, thr2_q, thr3_q;
  logic                    load1;

  assign load1 = s_axis_tvalid_i && en1;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      err_r_q  <= ERR_W'(roll_rate) - ERR_W'(roll_target);
      err_p_q  <= ERR_W'(pitch_rate) - ERR_W'(pitch_target);
      err_y_q  <= ERR_W'(yaw_rate) - ERR_W'(yaw_target);
      clear1_q <= clear_loop;
      thr1_q   <= thr_capped;
      armed1_q <= armed;
    end
    if (v1_q && en2) begin
      thr2_q   <= thr1_q;
      armed2_q <= armed1_q;
    end
    if (v2_q && en3) begin
      thr3_q   <= thr2_q;
      armed3_q <= armed2_q;
    end
  end

  // stages 2 and 3: pid per axis
  qrpm_pkg::axis_ctrl_t    axis_ctrl;
  logic signed [PID_W-1:0] pid_r, pid_p, pid_y;

  assign axis_ctrl = '{adv_b: v1_q && en2, adv_c: v2_q && en3};

  qrpm_axis #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_axis_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (axis_ctrl),
    .err_i   (err_r_q),
    .clear_i (clear1_q),
    .gains_i (gains_rp),
    .limit_i (limit_q),
    .pid_o   (pid_r)
  );

  qrpm_axis #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_axis_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (axis_ctrl),
    .err_i   (err_p_q),
    .clear_i (clear1_q),
    .gains_i (gains_rp),
    .limit_i (limit_q),
    .pid_o   (pid_p)
  );

  qrpm_axis #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_axis_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (axis_ctrl),
    .err_i   (err_y_q),
    .clear_i (clear1_q),
    .gains_i (gains_yw),
    .limit_i (limit_q),
    .pid_o   (pid_y)
  );

  // stage 4: mix into the output register
  logic [MOTOR_W-1:0] m_fr, m_rr, m_rl, m_fl;

  qrpm_mixer u_mixer (
    .clk_i         (clk_i),
    .load_i        (v3_q && en4),
    .roll_i        (pid_r),
    .pitch_i       (pid_p),
    .yaw_i         (pid_y),
    .throttle_i    (thr3_q),
    .armed_i       (armed3_q),
    .front_right_o (m_fr),
    .rear_right_o  (m_rr),
    .rear_left_o   (m_rl),
    .front_left_o  (m_fl)
  );

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {4'b0000, m_fl, m_rl, m_rr, m_fr};

endmodule

`default_nettype wire

// ===== sv/qrpm_checker.sv =====
// port-level checks on the quad rate pid mixer, bound to the top level
`default_nettype none

module qrpm_port_checks (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  s_axis_tready_o,
  input wire                                  m_axis_tvalid_o,
  input wire                                  m_axis_tready_i,
  input wire logic [qrpm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int MOTOR_W = qrpm_pkg::MOTOR_W;

  logic [MOTOR_W-1:0] fr, rr, rl, fl;
  logic               ok_fr, ok_rr, ok_rl, ok_fl, motors_ok;

  function automatic logic pulse_ok(input logic [MOTOR_W-1:0] v);
    return (v == qrpm_pkg::MOTOR_IDLE) ||
           ((v >= qrpm_pkg::MOTOR_LOW) && (v <= qrpm_pkg::MOTOR_HIGH));
  endfunction

  always_comb begin
    fr        = m_axis_tdata_o[10:0];
    rr        = m_axis_tdata_o[21:11];
    rl        = m_axis_tdata_o[32:22];
    fl        = m_axis_tdata_o[43:33];
    ok_fr     = pulse_ok(fr);
    ok_rr     = pulse_ok(rr);
    ok_rl     = pulse_ok(rl);
    ok_fl     = pulse_ok(fl);
    motors_ok = ok_fr && ok_rr && ok_rl && ok_fl;
  end

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // with nothing waiting at the output the pipe must take input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // every pulse is idle or inside the flight window
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> motors_ok)
    else $error("motor pulse out of range");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[47:44] == 4'b0000))
    else $error("pad bits of result beat not zero");

endmodule

bind quad_rate_pid_mixer_core qrpm_port_checks u_qrpm_port_checks (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
